/* src/sadc_pkg.sv */
// Shared types and constants for the set-associative data cache.
`default_nettype none
package sadc_pkg;

  localparam int unsigned DefWayBytes = 4096;
  localparam int unsigned DefLineWords = 8;
  localparam int unsigned DefMaxWays = 4;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 3;
  localparam logic [CfgIdxW-1:0] CFG_WAYS_IN_USE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_BACK = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALLOC_STORE = 2'd2;

  typedef enum logic [1:0] {
    KIND_RESP      = 2'd0,
    KIND_BUS_READ  = 2'd1,
    KIND_BUS_WRITE = 2'd2
  } kind_e;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] memory_word;
  } sadc_req_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] bus_address;
    logic [31:0] word;
    logic        hit;
    logic        last;
  } sadc_rsp_t;

endpackage
`default_nettype wire

/* src/sadc_meta_ram.sv */
// Line metadata memory: one row per line index holding tag, valid and dirty masks of all ways.
`default_nettype none
module sadc_meta_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned RowW = 144
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [RowW-1:0]          wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [RowW-1:0]               rdata_o
);

  logic [RowW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/sadc_data_ram.sv */
// Line word memory, one 32-bit word per entry, indexed by way and word within the way.
`default_nettype none
module sadc_data_ram #(
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [31:0]              wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [31:0]                   rdata_o
);

  logic [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/set_assoc_data_cache_unit.sv */
// Top level: access sequencer of the set-associative data cache around its two memories.
// A read hit presents its response after the metadata and data memory reads, a write-back store hit
// after the metadata read; a line replacement first writes back each dirty victim word, and a bus read
// or write-through emits its bus transaction before the response. One access at a time: the next is
// accepted the cycle after the response is emitted.
// Reset: after rst_ni deasserts, a clearing pass writes all 128 metadata rows, one per cycle.
`default_nettype none
module set_assoc_data_cache_unit import sadc_pkg::*; #(
  parameter int unsigned WAY_BYTES = DefWayBytes,
  parameter int unsigned LINE_WORDS = DefLineWords,
  parameter int unsigned MAX_WAYS = DefMaxWays
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sadc_req_t           in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sadc_rsp_t                out_rsp_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned OffW = $clog2(WAY_BYTES);
  localparam int unsigned TagW = 32 - OffW;
  localparam int unsigned PosW = $clog2(LINE_WORDS);
  localparam int unsigned WiW = OffW - 2;
  localparam int unsigned LineW = WiW - PosW;
  localparam int unsigned WayLines = WAY_BYTES / (4 * LINE_WORDS);
  localparam int unsigned WayWords = WAY_BYTES / 4;
  localparam int unsigned WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned EntryW = TagW + 2 * LINE_WORDS;
  localparam int unsigned RowW = MAX_WAYS * EntryW;
  localparam int unsigned DataDepth = MAX_WAYS * WayWords;
  localparam int unsigned DataAw = $clog2(DataDepth);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_META  = 4'd2;
  localparam logic [3:0] S_RDHIT = 4'd3;
  localparam logic [3:0] S_FLSEL = 4'd4;
  localparam logic [3:0] S_FLOUT = 4'd5;
  localparam logic [3:0] S_BUSRD = 4'd6;
  localparam logic [3:0] S_WT    = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [3:0]            state_q, state_d;
  sadc_req_t             req_q, req_d;
  logic [LineW-1:0]      clr_q, clr_d;
  logic [WayW-1:0]       ptr_q, ptr_d;
  logic [2:0]            ways_q;
  logic                  wb_q, alloc_q;
  logic [WayW-1:0]       way_q, way_d;
  logic [LINE_WORDS-1:0] fl_mask_q, fl_mask_d;
  logic [TagW-1:0]       fl_tag_q, fl_tag_d;
  logic [PosW-1:0]       fl_j_q, fl_j_d;
  logic                  hitw_q, hitw_d;
  logic                  commit_q, commit_d;
  logic                  out_valid_q, out_valid_d;
  sadc_rsp_t             out_q, out_d;

  logic                  meta_we, meta_re;
  logic [LineW-1:0]      meta_wa, meta_ra;
  logic [RowW-1:0]       meta_wd, meta_rd;
  logic                  data_we, data_re;
  logic [DataAw-1:0]     data_wa, data_ra;
  logic [31:0]           data_wd, data_rd;

  sadc_meta_ram #(.Depth(WayLines), .RowW(RowW)) u_meta (
    .clk_i, .we_i(meta_we), .waddr_i(meta_wa), .wdata_i(meta_wd),
    .re_i(meta_re), .raddr_i(meta_ra), .rdata_o(meta_rd)
  );

  sadc_data_ram #(.Depth(DataDepth)) u_data (
    .clk_i, .we_i(data_we), .waddr_i(data_wa), .wdata_i(data_wd),
    .re_i(data_re), .raddr_i(data_ra), .rdata_o(data_rd)
  );

  // Fields of the current access.
  logic [WiW-1:0]        cur_wi;
  logic [LineW-1:0]      cur_line;
  logic [PosW-1:0]       cur_pos;
  logic [TagW-1:0]       cur_tag;
  logic [LINE_WORDS-1:0] cur_k;
  logic [31:0]           cur_waddr;
  assign cur_wi = req_q.address[OffW-1:2];
  assign cur_line = cur_wi[WiW-1:PosW];
  assign cur_pos = cur_wi[PosW-1:0];
  assign cur_tag = req_q.address[31:OffW];
  assign cur_k = LINE_WORDS'(1) << cur_pos;
  assign cur_waddr = {req_q.address[31:2], 2'b00};

  // Lookup over the metadata row.
  logic [2:0]            eff_ways;
  logic                  found, any_empty;
  logic [WayW-1:0]       found_way, empty_way, ptr_v, victim;
  logic [EntryW-1:0]     f_entry, v_entry;
  logic [LINE_WORDS-1:0] low_bit;
  logic [PosW-1:0]       low_j;

  always_comb begin
    if (ways_q == 3'd0) begin
      eff_ways = 3'd1;
    end else if (ways_q > 3'(MAX_WAYS)) begin
      eff_ways = 3'(MAX_WAYS);
    end else begin
      eff_ways = ways_q;
    end
    found = 1'b0;
    any_empty = 1'b0;
    found_way = '0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (3'(w) < eff_ways) begin
        if (meta_rd[w*EntryW+2*LINE_WORDS +: TagW] == cur_tag) begin
          found = 1'b1;
          found_way = WayW'(w);
        end
        if (meta_rd[w*EntryW+LINE_WORDS +: LINE_WORDS] == '0) begin
          any_empty = 1'b1;
          empty_way = WayW'(w);
        end
      end
    end
    ptr_v = (3'(ptr_q) < eff_ways) ? ptr_q : '0;
    victim = any_empty ? empty_way : ptr_v;
    f_entry = meta_rd[found_way*EntryW +: EntryW];
    v_entry = meta_rd[victim*EntryW +: EntryW];
    low_j = '0;
    for (int i = LINE_WORDS - 1; i >= 0; i--) begin
      if (fl_mask_q[i]) begin
        low_j = PosW'(i);
      end
    end
    low_bit = LINE_WORDS'(1) << low_j;
  end

  logic can_emit;
  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    clr_d = clr_q;
    ptr_d = ptr_q;
    way_d = way_q;
    fl_mask_d = fl_mask_q;
    fl_tag_d = fl_tag_q;
    fl_j_d = fl_j_q;
    hitw_d = hitw_q;
    commit_d = commit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    meta_we = 1'b0;
    meta_wa = cur_line;
    meta_wd = meta_rd;
    meta_re = 1'b0;
    meta_ra = in_req_i.address[OffW-1:PosW+2];
    data_we = 1'b0;
    data_wa = DataAw'({way_q, cur_wi});
    data_wd = (req_q.opcode == OP_WRITE) ? req_q.write_data : req_q.memory_word;
    data_re = 1'b0;
    data_ra = DataAw'({way_q, cur_wi});

    unique case (state_q)
      S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_q;
        meta_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == LineW'(WayLines - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          meta_re = 1'b1;
          state_d = S_META;
        end
      end
      S_META: begin
        hitw_d = 1'b0;
        commit_d = 1'b1;
        if (found && (req_q.opcode == OP_READ || !alloc_q || found)) begin
          way_d = found_way;
          meta_we = 1'b1;
          meta_wd[found_way*EntryW + LINE_WORDS +: LINE_WORDS] =
            f_entry[LINE_WORDS +: LINE_WORDS] | cur_k;
          if (req_q.opcode == OP_READ) begin
            if ((f_entry[LINE_WORDS +: LINE_WORDS] & cur_k) != '0) begin
              meta_we = 1'b0;
              commit_d = 1'b0;
              data_re = 1'b1;
              data_ra = DataAw'({found_way, cur_wi});
              state_d = S_RDHIT;
            end else begin
              state_d = S_BUSRD;
            end
          end else begin
            hitw_d = (f_entry[LINE_WORDS +: LINE_WORDS] & cur_k) != '0;
            if (wb_q) begin
              meta_wd[found_way*EntryW +: LINE_WORDS] = f_entry[LINE_WORDS-1:0] | cur_k;
              state_d = S_RESP;
            end else begin
              state_d = S_WT;
            end
          end
        end else if (req_q.opcode == OP_READ || alloc_q) begin
          if (!any_empty) begin
            ptr_d = (3'(ptr_v) + 3'd1 >= eff_ways) ? '0 : ptr_v + 1'b1;
          end
          way_d = victim;
          fl_mask_d = v_entry[LINE_WORDS-1:0];
          fl_tag_d = v_entry[2*LINE_WORDS +: TagW];
          meta_we = 1'b1;
          meta_wd[victim*EntryW +: EntryW] = {cur_tag, cur_k,
            (req_q.opcode == OP_WRITE && wb_q) ? cur_k : LINE_WORDS'(0)};
          state_d = S_FLSEL;
        end else begin
          commit_d = 1'b0;
          state_d = S_WT;
        end
      end
      S_RDHIT: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d = '{kind: KIND_RESP, bus_address: cur_waddr, word: data_rd,
                    hit: 1'b1, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_FLSEL: begin
        if (fl_mask_q == '0) begin
          if (req_q.opcode == OP_READ) begin
            state_d = S_BUSRD;
          end else begin
            state_d = wb_q ? S_RESP : S_WT;
          end
        end else begin
          data_re = 1'b1;
          data_ra = DataAw'({way_q, cur_line, low_j});
          fl_j_d = low_j;
          fl_mask_d = fl_mask_q & ~low_bit;
          state_d = S_FLOUT;
        end
      end
      S_FLOUT: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d = '{kind: KIND_BUS_WRITE, bus_address: {fl_tag_q, cur_line, fl_j_q, 2'b00},
                    word: data_rd, hit: 1'b0, last: 1'b0};
          state_d = S_FLSEL;
        end
      end
      S_BUSRD: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d = '{kind: KIND_BUS_READ, bus_address: cur_waddr, word: 32'd0,
                    hit: 1'b0, last: 1'b0};
          state_d = S_RESP;
        end
      end
      S_WT: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d = '{kind: KIND_BUS_WRITE, bus_address: cur_waddr, word: req_q.write_data,
                    hit: 1'b0, last: 1'b0};
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d = '{kind: KIND_RESP, bus_address: cur_waddr,
                    word: (req_q.opcode == OP_WRITE) ? 32'd0 : req_q.memory_word,
                    hit: hitw_q, last: 1'b1};
          data_we = commit_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      ptr_q <= '0;
      ways_q <= 3'd4;
      wb_q <= 1'b1;
      alloc_q <= 1'b1;
      out_valid_q <= 1'b0;
      commit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      ptr_q <= ptr_d;
      out_valid_q <= out_valid_d;
      commit_q <= commit_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WAYS_IN_USE: ways_q <= cfg_data_i;
          CFG_WRITE_BACK:  wb_q <= cfg_data_i[0];
          CFG_ALLOC_STORE: alloc_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    way_q <= way_d;
    fl_mask_q <= fl_mask_d;
    fl_tag_q <= fl_tag_d;
    fl_j_q <= fl_j_d;
    hitw_q <= hitw_d;
    out_q <= out_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o = out_q;
  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire

/* src/sadc_checker.sv */
// Port-level checker for the data cache top level, attached by bind.
`default_nettype none
module sadc_checker import sadc_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire sadc_rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("output transaction changed while stalled");

  a_resp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_rsp_o.kind == KIND_RESP) == out_rsp_o.last))
    else $error("last must mark exactly the response");

  a_bus_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.kind != KIND_RESP |-> !out_rsp_o.hit)
    else $error("bus transaction carries a hit flag");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second access accepted while one is in flight");

endmodule

bind set_assoc_data_cache_unit sadc_checker u_sadc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_rsp_o
);
`default_nettype wire
